FILE: rtl/bhmf_pkg.sv
// ----------------------------------------------------------------------------
// Byte histogram mode finder package
// Shared constants for the byte histogram and its count memory.
// ----------------------------------------------------------------------------
package bhmf_pkg;

   localparam int COUNT_WIDTH_DEF = 32;
   localparam int BIN_COUNT       = 256;
   localparam int BIN_W           = $clog2(BIN_COUNT);

   typedef logic [BIN_W-1:0] bin_type;

endpackage

FILE: rtl/bhmf_count_ram.sv
// ----------------------------------------------------------------------------
// Histogram count memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bhmf_count_ram
   import bhmf_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic                   clock,
   input  logic                   wr_en,
   input  bin_type                wr_addr,
   input  logic [COUNT_WIDTH-1:0] wr_data,
   input  logic                   rd_en,
   input  bin_type                rd_addr,
   output logic [COUNT_WIDTH-1:0] rd_data
);

   logic [COUNT_WIDTH-1:0] mem [BIN_COUNT];
   logic [COUNT_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/byte_histogram_mode_finder.sv
// Timing: a transaction is read in the cycle it is accepted and counted in the
//   next, later if stage 1 is held; a last one's result is then registered.
// Throughput: one transaction per cycle while stage 1 is not held, set by the
//   single count-memory read-modify-write, with forwarding on repeated bins.
// Reset: per-bin valid bits clear on reset; no memory sweep is needed.
// ----------------------------------------------------------------------------
// Byte histogram mode finder
// Counts bytes in a 256-bin saturating histogram and reports the most frequent
// byte (lowest on ties) at the end of each stream, then starts over.
// ----------------------------------------------------------------------------
module byte_histogram_mode_finder
   import bhmf_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  logic [7:0]   req_data_byte,
   input  logic         req_has_byte,
   input  logic         req_is_last,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output logic [7:0]   rsp_frequent_byte
);

   localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

   logic                   req_fire;
   logic                   s1_go;

   logic                   s1_vld_ff,  s1_vld_in;
   bin_type                s1_byte_ff;
   logic                   s1_has_ff;
   logic                   s1_last_ff;
   logic                   s1_hit_ff;
   logic                   s1_fwd_ff,  s1_fwd_in;
   logic [COUNT_WIDTH-1:0] s1_fwd_cnt_ff, s1_fwd_cnt_in;

   logic [BIN_COUNT-1:0]   valid_ff,   valid_in;
   logic [COUNT_WIDTH-1:0] best_count_ff, best_count_in;
   bin_type                best_value_ff, best_value_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   bin_type                rsp_byte_ff;

   logic [COUNT_WIDTH-1:0] rd_data;
   logic [COUNT_WIDTH-1:0] cnt_old;
   logic [COUNT_WIDTH-1:0] cnt_new;
   logic                   better;
   logic [COUNT_WIDTH-1:0] upd_count;
   bin_type                upd_value;

   // Stage 1 holds only when a last transaction meets a full output register.
   assign s1_go     = s1_vld_ff && !(s1_last_ff && rsp_valid_ff && !rsp_ready);
   assign req_ready = !s1_vld_ff || s1_go;
   assign req_fire  = req_valid && req_ready;

   bhmf_count_ram #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (s1_go && s1_has_ff),
      .wr_addr (s1_byte_ff),
      .wr_data (cnt_new),
      .rd_en   (req_fire),
      .rd_addr (req_data_byte),
      .rd_data (rd_data)
   );

   always_comb begin
      if (s1_fwd_ff) begin
         cnt_old = s1_fwd_cnt_ff;
      end else if (s1_hit_ff) begin
         cnt_old = rd_data;
      end else begin
         cnt_old = '0;
      end
      cnt_new = (cnt_old == CNT_MAX) ? cnt_old : cnt_old + COUNT_WIDTH'(1);
      better  = (cnt_new > best_count_ff) ||
                ((cnt_new == best_count_ff) && (s1_byte_ff < best_value_ff));
      if (s1_has_ff && better) begin
         upd_count = cnt_new;
         upd_value = s1_byte_ff;
      end else begin
         upd_count = best_count_ff;
         upd_value = best_value_ff;
      end
   end

   always_comb begin
      s1_vld_in     = s1_vld_ff;
      s1_fwd_in     = 1'b0;
      s1_fwd_cnt_in = '0;
      valid_in      = valid_ff;
      best_count_in = best_count_ff;
      best_value_in = best_value_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;

      if (s1_go) begin
         s1_vld_in = 1'b0;
         if (s1_last_ff) begin
            valid_in      = '0;
            best_count_in = '0;
            best_value_in = '0;
            rsp_valid_in  = 1'b1;
         end else begin
            if (s1_has_ff) begin
               valid_in[s1_byte_ff] = 1'b1;
            end
            best_count_in = upd_count;
            best_value_in = upd_value;
         end
      end

      if (req_fire) begin
         s1_vld_in = 1'b1;
         if (s1_go) begin
            priority if (s1_last_ff) begin
               s1_fwd_in     = 1'b1;
               s1_fwd_cnt_in = '0;
            end else if (s1_has_ff && (s1_byte_ff == req_data_byte)) begin
               s1_fwd_in     = 1'b1;
               s1_fwd_cnt_in = cnt_new;
            end else begin
               s1_fwd_in     = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff     <= 1'b0;
         s1_fwd_ff     <= 1'b0;
         valid_ff      <= '0;
         best_count_ff <= '0;
         best_value_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         s1_vld_ff     <= s1_vld_in;
         valid_ff      <= valid_in;
         best_count_ff <= best_count_in;
         best_value_ff <= best_value_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (req_fire) begin
            s1_fwd_ff <= s1_fwd_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_byte_ff    <= req_data_byte;
         s1_has_ff     <= req_has_byte;
         s1_last_ff    <= req_is_last;
         s1_hit_ff     <= valid_ff[req_data_byte];
         s1_fwd_cnt_ff <= s1_fwd_cnt_in;
      end
      if (s1_go && s1_last_ff) begin
         rsp_byte_ff <= upd_value;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_frequent_byte = rsp_byte_ff;

endmodule

FILE: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// Byte histogram mode finder testbench
// Sends byte streams through the request channel and checks each reported
// mode against a local histogram predictor. It runs directed corner streams,
// long runs on repeated bins, random streams under several idle and stall
// patterns, and a long response hold-off that fills the block.
// ----------------------------------------------------------------------------
module testbench
   import bhmf_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TB_COUNT_WIDTH = COUNT_WIDTH_DEF;
   localparam int STALL_LIMIT    = 5000;
   localparam int END_SLACK      = 8;

   typedef logic [TB_COUNT_WIDTH-1:0] tally_type;

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_ready;
   logic [7:0] req_data_byte;
   logic       req_has_byte;
   logic       req_is_last;
   logic       rsp_valid;
   logic       rsp_ready;
   logic [7:0] rsp_frequent_byte;

   tally_type  tally_counts [BIN_COUNT];
   tally_type  lead_count;
   logic [7:0] lead_value;
   logic [7:0] expected_modes [$];
   logic [7:0] mode_want;

   int send_idle_pct;
   int recv_stall_pct;
   int hold_cycles;
   int error_count;
   int result_index;
   int quiet_cycles;

   byte_histogram_mode_finder #(
      .COUNT_WIDTH(TB_COUNT_WIDTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_data_byte     (req_data_byte),
      .req_has_byte      (req_has_byte),
      .req_is_last       (req_is_last),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_frequent_byte (rsp_frequent_byte)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic void clear_tally();
      foreach (tally_counts[i]) tally_counts[i] = '0;
      lead_count = '0;
      lead_value = 8'd0;
   endfunction

   function automatic void tally_transaction(logic [7:0] value, logic has_byte, logic last);
      tally_type  cnt;
      logic [7:0] mode;
      if (has_byte) begin
         cnt = tally_counts[value];
         if (cnt != '1) cnt = cnt + tally_type'(1);
         tally_counts[value] = cnt;
         if (cnt > lead_count) begin
            lead_count = cnt;
            lead_value = value;
         end else if (cnt == lead_count && value < lead_value) begin
            lead_value = value;
         end
      end
      if (last) begin
         mode = (lead_count == '0) ? 8'd0 : lead_value;
         expected_modes = {expected_modes, mode};
         clear_tally();
      end
   endfunction

   task automatic report_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic send_item(input logic [7:0] value, input logic has_byte, input logic last);
      @(negedge clock);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid     = 1'b0;
         req_data_byte = 8'($urandom);
         req_has_byte  = 1'($urandom);
         req_is_last   = 1'($urandom);
         @(negedge clock);
      end
      req_valid     = 1'b1;
      req_data_byte = value;
      req_has_byte  = has_byte;
      req_is_last   = last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tally_transaction(value, has_byte, last);
   endtask

   task automatic send_run(input logic [7:0] value, input int count);
      for (int i = 0; i < count; i++) send_item(value, 1'b1, 1'b0);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_modes.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_item(8'h00, 1'b0, 1'b1);        // empty stream
      send_item(8'hAA, 1'b0, 1'b0);        // neither byte nor last
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'hFF, 1'b1, 1'b1);        // byte on last
      send_item(8'h00, 1'b1, 1'b1);
      send_item(8'h80, 1'b1, 1'b0);        // tie, lower wins
      send_item(8'h7F, 1'b1, 1'b0);
      send_item(8'h80, 1'b1, 1'b0);
      send_item(8'h7F, 1'b1, 1'b0);
      send_item(8'h00, 1'b0, 1'b1);
      send_item(8'h20, 1'b1, 1'b0);        // tie closed by last byte
      send_item(8'h10, 1'b1, 1'b0);
      send_item(8'h20, 1'b1, 1'b0);
      send_item(8'h10, 1'b1, 1'b1);
      send_item(8'h01, 1'b1, 1'b0);        // later value overtakes
      send_item(8'hFE, 1'b1, 1'b0);
      send_item(8'h55, 1'b0, 1'b0);
      send_item(8'hFE, 1'b1, 1'b0);
      send_item(8'hC3, 1'b0, 1'b1);
      drain_results();
   endtask

   task automatic test_long_runs();
      send_run(8'hC3, 40);                 // equal long runs, tie to lower
      send_run(8'h3C, 40);
      send_item(8'h00, 1'b0, 1'b1);
      send_run(8'h01, 50);
      send_run(8'hF0, 60);
      send_item(8'h02, 1'b1, 1'b1);
      send_run(8'hE7, 70);                 // lower bin draws level on last
      send_run(8'h05, 69);
      send_item(8'h05, 1'b1, 1'b1);
      drain_results();
   endtask

   task automatic test_random_streams(input int idle_pct, input int stall_pct, input int goal);
      int         sent;
      int         len;
      int         span;
      logic [7:0] base;
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      sent = 0;
      while (sent < goal) begin
         base = 8'($urandom);
         if ($urandom_range(0, 99) == 0) begin
            len  = $urandom_range(100, 200);
            span = 1;
         end else begin
            len  = $urandom_range(0, 24);
            span = ($urandom_range(0, 3) == 0) ? 255 : $urandom_range(0, 3);
         end
         for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'(base + $urandom_range(0, span)), 1'b1, 1'b0);
            sent++;
         end
         send_item(($urandom_range(0, 1) == 0) ? 8'(base + $urandom_range(0, span))
                                               : 8'($urandom),
                   1'($urandom), 1'b1);
         sent++;
      end
      drain_results();
   endtask

   task automatic test_backpressure();
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_cycles    = 400;
      for (int i = 0; i < 60; i++) begin
         send_item(8'($urandom), 1'($urandom), 1'b0);
         send_item(8'($urandom), 1'b1, 1'b1);
      end
      drain_results();
   endtask

   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            rsp_ready = 1'b0;
            hold_cycles--;
         end else begin
            rsp_ready = ($urandom_range(0, 99) >= recv_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_modes.size() == 0) begin
            report_mismatch($sformatf("unexpected result frequent_byte=%02h",
                                      rsp_frequent_byte));
         end else begin
            mode_want = expected_modes.pop_front();
            if (rsp_frequent_byte !== mode_want)
               report_mismatch($sformatf("result %0d frequent_byte=%02h, expected %02h",
                                         result_index, rsp_frequent_byte, mode_want));
         end
         result_index++;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
         $display("FAILED: results differ");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_data_byte  = 8'd0;
      req_has_byte   = 1'b0;
      req_is_last    = 1'b0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      hold_cycles    = 0;
      error_count    = 0;
      result_index   = 0;
      quiet_cycles   = 0;
      clear_tally();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_long_runs();
      test_random_streams(0, 0, 350);
      test_random_streams(85, 0, 350);
      test_random_streams(0, 85, 350);
      test_random_streams(9, 9, 350);
      test_backpressure();

      repeat (END_SLACK) @(posedge clock);
      if (expected_modes.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", expected_modes.size()));
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
